@@ design/clcd_pkg.sv @@
// Package for the character LCD 4-bit sequencer.
// Holds opcodes, LCD command bytes, the queued command word and shared structs.
// Depends on nothing.
package clcd_pkg;

   localparam int unsigned QueueDepth = 2;

   typedef enum logic [2:0] {
      OP_INIT       = 3'd0,
      OP_WRITE_CHAR = 3'd1,
      OP_SET_POS    = 3'd2,
      OP_SET_FLAG   = 3'd3,
      OP_RAW_BYTE   = 3'd4
   } opcode_type;

   localparam logic [1:0] CSR_FUNCTION_SET    = 2'd0;
   localparam logic [1:0] CSR_DISPLAY_CONTROL = 2'd1;
   localparam logic [1:0] CSR_SECOND_LINE     = 2'd2;

   localparam logic [1:0] FLAG_DISPLAY = 2'd2;

   localparam logic [7:0] CHAR_NEWLINE   = 8'h0A;
   localparam logic [7:0] CHAR_FORM_FEED = 8'h0C;
   localparam logic [7:0] CHAR_RETURN    = 8'h0D;

   localparam logic [7:0] LCD_CLEAR        = 8'h01;
   localparam logic [7:0] LCD_ENTRY_MODE   = 8'h06;
   localparam logic [7:0] LCD_DISPLAY_CTRL = 8'h08;
   localparam logic [7:0] LCD_FUNCTION_SET = 8'h20;
   localparam logic [7:0] LCD_SET_ADDR     = 8'h80;

   localparam logic [4:0] RESET_FUNCTION_SET    = 5'd8;
   localparam logic [2:0] RESET_DISPLAY_CONTROL = 3'd4;
   localparam logic [6:0] RESET_SECOND_LINE     = 7'd64;

   localparam logic [5:0] STEP_INIT_FIRST = 6'd0;
   localparam logic [5:0] STEP_LAST_WAKE  = 6'd9;
   localparam logic [5:0] STEP_BYTE_START = 6'd13;
   localparam logic [5:0] STEP_BYTE_LAST  = 6'd20;
   localparam logic [5:0] STEP_INIT_LAST  = 6'd44;

   localparam logic [3:0] NIB_WAKE = 4'd3;
   localparam logic [3:0] NIB_4BIT = 4'd2;

   localparam logic [4:0] WAIT_POWER_UP = 5'd15;
   localparam logic [4:0] WAIT_WAKE     = 5'd5;
   localparam logic [4:0] WAIT_BYTE     = 5'd3;
   localparam logic [4:0] WAIT_CLEAR    = 5'd8;
   localparam logic [4:0] WAIT_NONE     = 5'd0;

   typedef enum logic {
      CMD_INIT = 1'b0,
      CMD_BYTE = 1'b1
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic         rs;
      logic [7:0]   byte_val;
      logic         clear;
   } cmd_type;

   typedef struct packed {
      logic [4:0] function_set_bits;
      logic [2:0] display_control_bits;
   } init_cfg_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

@@ design/clcd_if.sv @@
// Handshake channels of the character LCD sequencer.
// Request channel carries commands, response channel carries pin states.
// Depends on nothing.
interface clcd_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] opcode;
   logic [7:0] value;
   logic       line;
   logic [5:0] column;
   logic [1:0] flag_select;
   logic       flag_on;
   logic       rs_flag;

   modport source (output valid, opcode, value, line, column, flag_select, flag_on, rs_flag,
                   input ready);
   modport sink (input valid, opcode, value, line, column, flag_select, flag_on, rs_flag,
                 output ready);
endinterface

interface clcd_rsp_if;
   logic       valid;
   logic       ready;
   logic [3:0] data_pins;
   logic       register_select;
   logic       enable;
   logic [4:0] wait_ms;
   logic       last;

   modport source (output valid, data_pins, register_select, enable, wait_ms, last,
                   input ready);
   modport sink (input valid, data_pins, register_select, enable, wait_ms, last,
                 output ready);
endinterface

@@ design/char_lcd_4bit_sequencer_top.sv @@
// Top level of the character LCD 4-bit sequencer.
// Ties front end, command queue and pin sequencer. Depends on clcd_pkg, clcd_if.
//
//   channel  | direction | handshake     | carries
//   req_port | in        | valid / ready | opcode, value, line, column, flags, rs
//   rsp_port | out       | valid / ready | data_pins, RS, E, wait_ms, last
//   csr_*    | in        | csr_we        | index 0..2, 7-bit write data
//
// One pin state leaves per cycle from the sequencer while rsp_port does not stall,
// set by the sequencer step counter behind the response register.
// Commands with no pin states are accepted in the front end and never reach the queue.
// The queue lets the front end accept commands while the sequencer is busy or stalled.
// Synchronous reset empties the queue and clears the mode byte and response valid.
module char_lcd_4bit_sequencer_top #(
   parameter int unsigned QUEUE_DEPTH = clcd_pkg::QueueDepth
) (
   input  logic       clock,
   input  logic       reset,
   clcd_req_if.sink   req_port,
   clcd_rsp_if.source rsp_port,
   input  logic       csr_we,
   input  logic [1:0] csr_index,
   input  logic [6:0] csr_wdata
);
   import clcd_pkg::*;

   queue_status_type q_status;
   logic             push;
   cmd_type          push_cmd;
   logic             pop;
   cmd_type          pop_cmd;
   init_cfg_type     init_cfg;

   clcd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_port  (req_port),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .q_status  (q_status),
      .push      (push),
      .push_cmd  (push_cmd),
      .init_cfg  (init_cfg)
   );

   clcd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .pop_cmd  (pop_cmd),
      .status   (q_status)
   );

   clcd_back u_back (
      .clock    (clock),
      .reset    (reset),
      .init_cfg (init_cfg),
      .q_status (q_status),
      .pop_cmd  (pop_cmd),
      .pop      (pop),
      .rsp_port (rsp_port)
   );

endmodule

@@ design/clcd_front.sv @@
// Front end: accepts commands, holds configuration and the display mode byte,
// turns each command with pin states into a queued init or byte word. Depends on clcd_pkg, clcd_if.
module clcd_front (
   input  logic                      clock,
   input  logic                      reset,
   clcd_req_if.sink                  req_port,
   input  logic                      csr_we,
   input  logic [1:0]                csr_index,
   input  logic [6:0]                csr_wdata,
   input  clcd_pkg::queue_status_type q_status,
   output logic                      push,
   output clcd_pkg::cmd_type         push_cmd,
   output clcd_pkg::init_cfg_type    init_cfg
);
   import clcd_pkg::*;

   logic [4:0] function_set_ff;
   logic [2:0] display_control_ff;
   logic [6:0] second_line_ff;
   logic [7:0] display_mode_ff;
   logic [7:0] display_mode_in;
   logic       accept;
   logic       has_work;
   logic [7:0] pos_sum;
   logic [7:0] flag_mask;
   logic [7:0] flag_mode;

   assign req_port.ready = !q_status.full;
   assign accept         = req_port.valid && req_port.ready;
   assign push           = accept && has_work;

   assign init_cfg.function_set_bits    = function_set_ff;
   assign init_cfg.display_control_bits = display_control_ff;

   assign pos_sum   = {1'b0, (req_port.line ? second_line_ff : 7'd0)}
                    + {2'b00, req_port.column};
   assign flag_mask = 8'd1 << req_port.flag_select;
   assign flag_mode = req_port.flag_on ? (display_mode_ff | flag_mask)
                                       : (display_mode_ff & ~flag_mask);

   always_comb begin
      has_work          = 1'b1;
      push_cmd.kind     = CMD_BYTE;
      push_cmd.rs       = 1'b0;
      push_cmd.byte_val = req_port.value;
      push_cmd.clear    = 1'b0;
      display_mode_in   = display_mode_ff;
      unique case (opcode_type'(req_port.opcode))
         OP_INIT: begin
            push_cmd.kind   = CMD_INIT;
            display_mode_in = LCD_DISPLAY_CTRL | {5'd0, display_control_ff};
         end
         OP_WRITE_CHAR: begin
            if (req_port.value == CHAR_FORM_FEED) begin
               push_cmd.byte_val = LCD_CLEAR;
               push_cmd.clear    = 1'b1;
            end else if (req_port.value == CHAR_NEWLINE) begin
               has_work = 1'b0;
            end else if (req_port.value == CHAR_RETURN) begin
               push_cmd.byte_val = LCD_SET_ADDR | {1'b0, second_line_ff};
            end else begin
               push_cmd.rs = 1'b1;
            end
         end
         OP_SET_POS: begin
            push_cmd.byte_val = LCD_SET_ADDR | {1'b0, pos_sum[6:0]};
         end
         OP_SET_FLAG: begin
            if (req_port.flag_select <= FLAG_DISPLAY) begin
               display_mode_in   = flag_mode;
               push_cmd.byte_val = flag_mode;
            end else begin
               has_work = 1'b0;
            end
         end
         OP_RAW_BYTE: begin
            push_cmd.rs = req_port.rs_flag;
         end
         default: begin
            has_work = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         function_set_ff    <= RESET_FUNCTION_SET;
         display_control_ff <= RESET_DISPLAY_CONTROL;
         second_line_ff     <= RESET_SECOND_LINE;
         display_mode_ff    <= 8'd0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_FUNCTION_SET:    function_set_ff    <= csr_wdata[4:0];
               CSR_DISPLAY_CONTROL: display_control_ff <= csr_wdata[2:0];
               CSR_SECOND_LINE:     second_line_ff     <= csr_wdata;
               default: ;
            endcase
         end
         if (accept) begin
            display_mode_ff <= display_mode_in;
         end
      end
   end

endmodule

@@ design/clcd_queue.sv @@
// Command queue between front end and pin sequencer.
// Small register file with read and write pointers. Depends on clcd_pkg.
module clcd_queue #(
   parameter int unsigned DEPTH = clcd_pkg::QueueDepth
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  clcd_pkg::cmd_type          push_cmd,
   input  logic                       pop,
   output clcd_pkg::cmd_type          pop_cmd,
   output clcd_pkg::queue_status_type status
);
   import clcd_pkg::*;

   localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CntW = $clog2(DEPTH + 1);
   localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);
   localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

   cmd_type         mem_ff [DEPTH];
   logic [PtrW-1:0] wr_ptr_ff;
   logic [PtrW-1:0] rd_ptr_ff;
   logic [CntW-1:0] count_ff;
   logic [PtrW-1:0] wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_in;
   logic [CntW-1:0] count_in;

   assign pop_cmd      = mem_ff[rd_ptr_ff];
   assign status.full  = (count_ff == CntFull);
   assign status.empty = (count_ff == '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrLast) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrLast) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CntW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

@@ design/clcd_back.sv @@
// Pin sequencer: expands a queued init or byte word into pin states,
// one per cycle while the response port does not stall, through the response register. Depends on clcd_pkg, clcd_if.
module clcd_back (
   input  logic                      clock,
   input  logic                      reset,
   input  clcd_pkg::init_cfg_type    init_cfg,
   input  clcd_pkg::queue_status_type q_status,
   input  clcd_pkg::cmd_type         pop_cmd,
   output logic                      pop,
   clcd_rsp_if.source                rsp_port
);
   import clcd_pkg::*;

   cmd_type    cmd_ff;
   cmd_type    cmd_in;
   logic       busy_ff;
   logic       busy_in;
   logic [5:0] step_ff;
   logic [5:0] step_in;
   logic [3:0] data_ff;
   logic [3:0] data_in;
   logic       valid_ff;
   logic       valid_in;
   logic [3:0] pins_ff;
   logic       rs_ff;
   logic       en_ff;
   logic [4:0] wait_ff;
   logic       last_ff;

   logic       can_load;
   logic       advance;
   logic [5:0] byte_step;
   logic [1:0] byte_idx;
   logic [2:0] sub;
   logic [7:0] byte_cur;
   logic       is_clear;
   logic [3:0] nib_cur;
   logic [3:0] st_data;
   logic       st_rs;
   logic       st_en;
   logic [4:0] st_wait;
   logic       st_last;

   assign rsp_port.valid           = valid_ff;
   assign rsp_port.data_pins       = pins_ff;
   assign rsp_port.register_select = rs_ff;
   assign rsp_port.enable          = en_ff;
   assign rsp_port.wait_ms         = wait_ff;
   assign rsp_port.last            = last_ff;

   assign can_load  = !valid_ff || rsp_port.ready;
   assign advance   = busy_ff && can_load;
   assign pop       = !q_status.empty && (!busy_ff || (advance && st_last));
   assign byte_step = step_ff - STEP_BYTE_START;
   assign byte_idx  = byte_step[4:3];
   assign sub       = byte_step[2:0];

   always_comb begin
      byte_cur = cmd_ff.byte_val;
      is_clear = cmd_ff.clear;
      if (cmd_ff.kind == CMD_INIT) begin
         is_clear = (byte_idx == 2'd2);
         case (byte_idx)
            2'd0:    byte_cur = LCD_FUNCTION_SET | {3'd0, init_cfg.function_set_bits};
            2'd1:    byte_cur = LCD_DISPLAY_CTRL | {5'd0, init_cfg.display_control_bits};
            2'd2:    byte_cur = LCD_CLEAR;
            default: byte_cur = LCD_ENTRY_MODE;
         endcase
      end
   end

   always_comb begin
      nib_cur = (step_ff <= STEP_LAST_WAKE) ? NIB_WAKE : NIB_4BIT;
      st_data = data_ff;
      st_rs   = 1'b0;
      st_en   = 1'b0;
      st_wait = WAIT_NONE;
      st_last = (cmd_ff.kind == CMD_INIT) ? (step_ff == STEP_INIT_LAST)
                                          : (step_ff == STEP_BYTE_LAST);
      if (step_ff == STEP_INIT_FIRST) begin
         st_data = 4'd0;
         st_wait = WAIT_POWER_UP;
      end else if (step_ff < STEP_BYTE_START) begin
         st_data = nib_cur;
         case (step_ff)
            6'd2, 6'd5, 6'd8, 6'd11: st_en = 1'b1;
            6'd3, 6'd6, 6'd9:        st_wait = WAIT_WAKE;
            default: ;
         endcase
      end else begin
         st_rs = cmd_ff.rs;
         st_en = (sub == 3'd3) || (sub == 3'd6);
         case (sub)
            3'd0, 3'd1:       st_data = data_ff;
            3'd2, 3'd3, 3'd4: st_data = byte_cur[7:4];
            default:          st_data = byte_cur[3:0];
         endcase
         if (sub == 3'd7) begin
            st_wait = is_clear ? WAIT_CLEAR : WAIT_BYTE;
         end
      end
   end

   always_comb begin
      cmd_in   = cmd_ff;
      busy_in  = busy_ff;
      step_in  = step_ff;
      data_in  = data_ff;
      valid_in = valid_ff && !rsp_port.ready;
      if (advance) begin
         valid_in = 1'b1;
         data_in  = st_data;
         step_in  = step_ff + 6'd1;
         if (st_last) begin
            busy_in = 1'b0;
         end
      end
      if (pop) begin
         cmd_in  = pop_cmd;
         busy_in = 1'b1;
         step_in = (pop_cmd.kind == CMD_INIT) ? STEP_INIT_FIRST : STEP_BYTE_START;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         valid_ff <= 1'b0;
         step_ff  <= STEP_INIT_FIRST;
         data_ff  <= 4'd0;
      end else begin
         busy_ff  <= busy_in;
         valid_ff <= valid_in;
         step_ff  <= step_in;
         data_ff  <= data_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      if (advance) begin
         pins_ff <= st_data;
         rs_ff   <= st_rs;
         en_ff   <= st_en;
         wait_ff <= st_wait;
         last_ff <= st_last;
      end
   end

endmodule
